// ===== rtl/trp_pkg.sv =====
// ---------------------------------------------------------------------------
// trp_pkg: shared types and constants of the tape image record parser
// register indexes, result kinds, load status codes, parse phases
// ---------------------------------------------------------------------------
package trp_pkg;

  localparam int unsigned DEF_MAX_RECORDS = 4096;

  localparam int unsigned REC_W  = 13;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CIDX_W = 3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_EOM_MARK  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_GAP_MARK  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_TAPE_MARK = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_LEN_MASK  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_TABLE_CAP = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_STORE_CAP = 3'd5;

  // operation codes of an input word
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA_BYTE = 2'd0,
    KIND_RECORD    = 2'd1,
    KIND_FILEMARK  = 2'd2,
    KIND_LOAD_DONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNCATED  = 3'd1,
    ST_MISMATCH   = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_STORE_FULL = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_DATA    = 3'd1,
    PH_PAD     = 3'd2,
    PH_TRAILER = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] eom_mark;
    logic [WORD_W-1:0] gap_mark;
    logic [WORD_W-1:0] tape_mark;
    logic [WORD_W-1:0] len_mask;
    logic [REC_W-1:0]  table_cap;
    logic [WORD_W-1:0] store_cap;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        payload_byte;
    logic [REC_W-1:0]  record_number;
    logic [WORD_W-1:0] store_offset;
    logic [WORD_W-1:0] record_length;
    status_t           status;
  } res_t;

endpackage

// ===== rtl/trp_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// trp_cfg_regs: configuration register file
// six write-only registers selected by index, unknown indexes dropped
// ---------------------------------------------------------------------------
module trp_cfg_regs
  import trp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  output cfg_t              cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.eom_mark  <= 32'hFFFF_FFFF;
      cfg_r.gap_mark  <= 32'hFFFF_FFFE;
      cfg_r.tape_mark <= 32'h0000_0000;
      cfg_r.len_mask  <= 32'h00FF_FFFF;
      cfg_r.table_cap <= 13'd1024;
      cfg_r.store_cap <= 32'h0100_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EOM_MARK:  cfg_r.eom_mark  <= cfg_data;
        CFG_GAP_MARK:  cfg_r.gap_mark  <= cfg_data;
        CFG_TAPE_MARK: cfg_r.tape_mark <= cfg_data;
        CFG_LEN_MASK:  cfg_r.len_mask  <= cfg_data;
        CFG_TABLE_CAP: cfg_r.table_cap <= cfg_data[REC_W-1:0];
        CFG_STORE_CAP: cfg_r.store_cap <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/trp_parser.sv =====
// ---------------------------------------------------------------------------
// trp_parser: record parse state and per-word decode
// one word per fire, result fields formed combinationally
// ---------------------------------------------------------------------------
module trp_parser
  import trp_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = DEF_MAX_RECORDS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic       op,
  input  logic [7:0] byte_in,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [16:0] MaxRec = 17'(MAX_RECORDS);

  phase_t            phase_r, phase_nxt;
  logic [WORD_W-1:0] count_r, count_nxt;
  logic [WORD_W-1:0] header_r, header_nxt;
  logic [WORD_W-1:0] trailer_r, trailer_nxt;
  logic [WORD_W-1:0] cur_len_r, cur_len_nxt;
  logic [REC_W-1:0]  records_r, records_nxt;
  logic [WORD_W-1:0] bytes_r, bytes_nxt;
  status_t           fail_r, fail_nxt;

  logic [WORD_W-1:0] asm_word;
  logic [WORD_W-1:0] count_inc;
  logic [WORD_W-1:0] new_len;
  logic [16:0]       eff_cap;
  logic              word_done;
  logic              is_eom, is_gap, is_mark;
  logic              table_full, store_over;

  // byte lane merge, shared by header and trailer assembly
  assign asm_word = ((phase_r == PH_TRAILER) ? trailer_r : header_r)
                  | ({24'b0, byte_in} << {count_r[1:0], 3'b000});
  assign count_inc = count_r + 32'd1;
  assign word_done = (count_r[1:0] == 2'd3);
  assign is_eom    = (asm_word == cfg.eom_mark);
  assign is_gap    = (asm_word == cfg.gap_mark);
  assign is_mark   = (asm_word == cfg.tape_mark);
  assign new_len   = asm_word & cfg.len_mask;

  assign eff_cap    = ({4'b0, cfg.table_cap} > MaxRec) ? MaxRec : {4'b0, cfg.table_cap};
  assign table_full = ({4'b0, records_r} >= eff_cap);
  assign store_over = (({1'b0, bytes_r} + {1'b0, new_len}) > {1'b0, cfg.store_cap});

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    header_nxt  = header_r;
    trailer_nxt = trailer_r;
    cur_len_nxt = cur_len_r;
    records_nxt = records_r;
    bytes_nxt   = bytes_r;
    fail_nxt    = fail_r;
    if (fire) begin
      if (op == OP_END) begin
        phase_nxt   = PH_HEADER;
        count_nxt   = '0;
        header_nxt  = '0;
        trailer_nxt = '0;
        cur_len_nxt = '0;
        records_nxt = '0;
        bytes_nxt   = '0;
        fail_nxt    = ST_OK;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            header_nxt = asm_word;
            count_nxt  = count_inc;
            if (word_done) begin
              if (is_eom) begin
                phase_nxt = PH_DONE;
                fail_nxt  = ST_OK;
              end else if (is_gap) begin
                header_nxt = '0;
                count_nxt  = '0;
              end else if (is_mark) begin
                if (table_full) begin
                  phase_nxt = PH_DONE;
                  fail_nxt  = ST_TABLE_FULL;
                end else begin
                  records_nxt = records_r + 13'd1;
                  header_nxt  = '0;
                  count_nxt   = '0;
                end
              end else begin
                cur_len_nxt = new_len;
                count_nxt   = '0;
                if (table_full)      fail_nxt = ST_TABLE_FULL;
                else if (store_over) fail_nxt = ST_STORE_FULL;
                else                 fail_nxt = ST_OK;
                if (new_len == '0) begin
                  trailer_nxt = '0;
                  phase_nxt   = PH_TRAILER;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
            end
          end
          PH_DATA: begin
            count_nxt = count_inc;
            if (count_inc >= cur_len_r) begin
              count_nxt   = '0;
              trailer_nxt = '0;
              phase_nxt   = cur_len_r[0] ? PH_PAD : PH_TRAILER;
            end
          end
          PH_PAD: begin
            phase_nxt   = PH_TRAILER;
            count_nxt   = '0;
            trailer_nxt = '0;
          end
          PH_TRAILER: begin
            trailer_nxt = asm_word;
            count_nxt   = count_inc;
            if (word_done) begin
              if (asm_word != header_r) begin
                phase_nxt = PH_DONE;
                fail_nxt  = ST_MISMATCH;
              end else if (fail_r != ST_OK) begin
                phase_nxt = PH_DONE;
              end else begin
                records_nxt = records_r + 13'd1;
                bytes_nxt   = bytes_r + cur_len_r;
                phase_nxt   = PH_HEADER;
                header_nxt  = '0;
                count_nxt   = '0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result of the word in hand
  always_comb begin
    res_valid         = 1'b0;
    res.kind          = KIND_DATA_BYTE;
    res.payload_byte  = '0;
    res.record_number = records_r;
    res.store_offset  = '0;
    res.record_length = '0;
    res.status        = ST_OK;
    if (fire) begin
      if (op == OP_END) begin
        res_valid        = 1'b1;
        res.kind         = KIND_LOAD_DONE;
        res.store_offset = bytes_r;
        if (phase_r == PH_DONE)        res.status = fail_r;
        else if (phase_r != PH_HEADER) res.status = ST_TRUNCATED;
        else                           res.status = ST_OK;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (word_done && !is_eom && !is_gap && is_mark && !table_full) begin
              res_valid = 1'b1;
              res.kind  = KIND_FILEMARK;
            end
          end
          PH_DATA: begin
            if (fail_r == ST_OK) begin
              res_valid         = 1'b1;
              res.kind          = KIND_DATA_BYTE;
              res.payload_byte  = byte_in;
              res.store_offset  = bytes_r + count_r;
              res.record_length = cur_len_r;
            end
          end
          PH_TRAILER: begin
            if (word_done && asm_word == header_r && fail_r == ST_OK) begin
              res_valid         = 1'b1;
              res.kind          = KIND_RECORD;
              res.store_offset  = bytes_r;
              res.record_length = cur_len_r;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      count_r   <= '0;
      header_r  <= '0;
      trailer_r <= '0;
      cur_len_r <= '0;
      records_r <= '0;
      bytes_r   <= '0;
      fail_r    <= ST_OK;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      header_r  <= header_nxt;
      trailer_r <= trailer_nxt;
      cur_len_r <= cur_len_nxt;
      records_r <= records_nxt;
      bytes_r   <= bytes_nxt;
      fail_r    <= fail_nxt;
    end
  end

  // header byte count stays inside one word
  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> count_r < 32'd4)
    else $error("header byte count out of range");

  // end mark returns the parser to a fresh image
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op == OP_END |=> phase_r == PH_HEADER && records_r == '0 && bytes_r == '0)
    else $error("end mark did not clear parse state");

  // record count only grows within one image
  a_rec_grow: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op == OP_BYTE |=> records_r >= $past(records_r))
    else $error("record count went backwards");

  // a data byte result only comes from the data phase
  a_byte_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == KIND_DATA_BYTE |-> phase_r == PH_DATA)
    else $error("data byte outside data phase");

endmodule

// ===== rtl/tape_image_record_parser.sv =====
// ---------------------------------------------------------------------------
// tape_image_record_parser: tape image record parser, top level
// splits a byte stream of a tape image into data bytes, records and filemarks
// ---------------------------------------------------------------------------
//  channel   direction  ports                                    handshake
//  in        sink       in_operation, in_image_byte              in_valid / in_stall
//  out       source     out_item_kind .. out_load_status         out_valid / out_stall
//  cfg       sink       cfg_index, cfg_data                      cfg_we, no wait
//
//  one word per clock sustained while out_stall is low; a word's result passes from
//  the input register through the parse step into the result register and is
//  taken at an edge with out_stall low
//  the throughput limit is the parse step on the state registers
//  synchronous active-low reset clears parse state and restores register defaults
//  out_stall holds the result register; the input register still takes one word
//  while the result waits, then in_stall rises
// ---------------------------------------------------------------------------
module tape_image_record_parser
  import trp_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = DEF_MAX_RECORDS
) (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [7:0]        in_image_byte,
  // result words
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_item_kind,
  output logic [7:0]        out_payload_byte,
  output logic [REC_W-1:0]  out_record_number,
  output logic [WORD_W-1:0] out_store_offset,
  output logic [WORD_W-1:0] out_record_length,
  output logic [2:0]        out_load_status,
  // configuration writes
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0] cfg_data
);

  cfg_t       cfg;
  res_t       res;
  logic       res_valid;

  // input register
  logic       in_valid_r;
  logic       in_op_r;
  logic [7:0] in_byte_r;

  // result register
  logic       out_valid_r;
  res_t       out_r;

  // the held word is parsed when the result register is free or draining
  logic       fire;
  logic       in_take;

  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  trp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  trp_parser #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .op        (in_op_r),
    .byte_in   (in_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // input word register: refills in the same cycle it is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r   <= in_operation;
      in_byte_r <= in_image_byte;
    end
  end

  // result register: a fire only happens when it is empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_item_kind     = out_r.kind;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_record_number = out_r.record_number;
  assign out_store_offset  = out_r.store_offset;
  assign out_record_length = out_r.record_length;
  assign out_load_status   = out_r.status;

  // a result waiting on a stall is never overwritten by a parse step
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !fire)
    else $error("parse step while result register is held");

  // a parsed word frees the input register unless a new word is taken
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !in_take |=> !in_valid_r)
    else $error("input register not drained");

  // a produced result is visible on the next cycle
  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid |=> out_valid_r)
    else $error("result lost");

endmodule
